// ===== hdl/gpa_pkg.sv =====
`default_nettype none
package gpa_pkg;

  // Fractional bits of positions, masses and accelerations.
  localparam int FRAC_BITS = 16;
  // The gravitational constant always carries 24 fractional bits.
  localparam int G_FRAC = 24;

  localparam logic [31:0] GRAV_RESET = 32'h0100_0000;

  // Distance magnitudes, square sums and the square root.
  localparam int U_W     = 33;
  localparam int RAD_W   = 2 * U_W;
  localparam int SQ_REM_W = U_W + 2;
  localparam int SQRT_N  = U_W;

  // Division cells: divisor/remainder width and quotient bits.
  // Every quotient in this block stays below 2^QUO_W.
  localparam int DIV_W = 2 * U_W;
  localparam int QUO_W = 40;
  localparam int DVD_W = DIV_W + QUO_W;

  // Scaling of G*m into the magnitude numerator, 2F-24 bits either way.
  localparam int NUM_SHL = (2 * FRAC_BITS > G_FRAC) ? 2 * FRAC_BITS - G_FRAC : 0;
  localparam int NUM_SHR = (2 * FRAC_BITS < G_FRAC) ? G_FRAC - 2 * FRAC_BITS : 0;

  localparam logic [U_W-1:0] DIST_ONE = U_W'(1) << FRAC_BITS;

  localparam int PP_SPLIT = QUO_W / 2;
  localparam int PROD_W   = QUO_W + U_W;
  localparam int COMP_N   = 4;

  typedef struct packed {
    logic signed [31:0] pos_a_x;
    logic signed [31:0] pos_a_y;
    logic signed [31:0] pos_b_x;
    logic signed [31:0] pos_b_y;
    logic        [31:0] mass_a;
    logic        [31:0] mass_b;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] accel_a_dx;
    logic signed [31:0] accel_a_dy;
    logic signed [31:0] accel_b_dx;
    logic signed [31:0] accel_b_dy;
    logic               saturated;
  } out_beat_t;

  typedef struct packed {
    logic x_neg;
    logic x_pos;
    logic y_neg;
    logic y_pos;
  } dir_t;

  typedef struct packed {
    dir_t           dir;
    logic [U_W-1:0] ux;
    logic [U_W-1:0] uy;
    logic [31:0]    mass_a;
    logic [31:0]    mass_b;
  } sq_side_t;

  typedef struct packed {
    dir_t           dir;
    logic [U_W-1:0] ux;
    logic [U_W-1:0] uy;
    logic [U_W-1:0] draw;
  } dv_side_t;

  // Returns {clipped, value} for a magnitude that gets the given sign.
  function automatic logic [32:0] sat_comp(logic [QUO_W-1:0] m, logic neg);
    logic [QUO_W-1:0] mm;
    logic             clip;
    clip = 1'b0;
    mm   = m;
    if (neg) begin
      if (m > QUO_W'(32'h8000_0000)) begin
        clip = 1'b1;
        mm   = QUO_W'(32'h8000_0000);
      end
      return {clip, 32'd0 - mm[31:0]};
    end
    if (m > QUO_W'(32'h7FFF_FFFF)) begin
      clip = 1'b1;
      mm   = QUO_W'(32'h7FFF_FFFF);
    end
    return {clip, mm[31:0]};
  endfunction

endpackage
`default_nettype wire

// ===== hdl/gpa_sqrt_cell.sv =====
`default_nettype none
// One root bit per cell: brings down the next bit pair and tries the subtract.
module gpa_sqrt_cell (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_vld,
  input  wire logic [gpa_pkg::RAD_W-1:0]     in_rad,
  input  wire logic [gpa_pkg::SQ_REM_W-1:0]  in_rem,
  input  wire logic [gpa_pkg::U_W-1:0]       in_root,
  input  wire gpa_pkg::sq_side_t             in_side,
  output logic                               out_vld,
  output logic [gpa_pkg::RAD_W-1:0]          out_rad,
  output logic [gpa_pkg::SQ_REM_W-1:0]       out_rem,
  output logic [gpa_pkg::U_W-1:0]            out_root,
  output gpa_pkg::sq_side_t                  out_side
);

  logic                              vld_r;
  logic [gpa_pkg::RAD_W-1:0]         rad_r, rad_nxt;
  logic [gpa_pkg::SQ_REM_W-1:0]      rem_r, rem_nxt;
  logic [gpa_pkg::U_W-1:0]           root_r, root_nxt;
  gpa_pkg::sq_side_t                 side_r;
  logic [gpa_pkg::SQ_REM_W+1:0]      rem_sh, trial;
  logic                              ge;

  always_comb begin
    rem_sh   = {in_rem, in_rad[gpa_pkg::RAD_W-1 -: 2]};
    trial    = {2'b00, in_root, 2'b01};
    ge       = rem_sh >= trial;
    rem_nxt  = ge ? gpa_pkg::SQ_REM_W'(rem_sh - trial) : gpa_pkg::SQ_REM_W'(rem_sh);
    root_nxt = {in_root[gpa_pkg::U_W-2:0], ge};
    rad_nxt  = {in_rad[gpa_pkg::RAD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    side_r <= in_side;
  end

  assign out_vld  = vld_r;
  assign out_rad  = rad_r;
  assign out_rem  = rem_r;
  assign out_root = root_r;
  assign out_side = side_r;

endmodule
`default_nettype wire

// ===== hdl/gpa_div_cell.sv =====
`default_nettype none
// One quotient bit per cell of a restoring divider. The word shifts the
// remaining dividend bits out at the top and the quotient bits in at the bottom.
module gpa_div_cell (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_vld,
  input  wire logic [gpa_pkg::DIV_W-1:0]   in_rem,
  input  wire logic [gpa_pkg::QUO_W-1:0]   in_word,
  input  wire logic [gpa_pkg::DIV_W-1:0]   in_dvs,
  input  wire gpa_pkg::dv_side_t           in_side,
  output logic                             out_vld,
  output logic [gpa_pkg::DIV_W-1:0]        out_rem,
  output logic [gpa_pkg::QUO_W-1:0]        out_word,
  output logic [gpa_pkg::DIV_W-1:0]        out_dvs,
  output gpa_pkg::dv_side_t                out_side
);

  logic                          vld_r;
  logic [gpa_pkg::DIV_W-1:0]     rem_r, rem_nxt;
  logic [gpa_pkg::QUO_W-1:0]     word_r, word_nxt;
  logic [gpa_pkg::DIV_W-1:0]     dvs_r;
  gpa_pkg::dv_side_t             side_r;
  logic [gpa_pkg::DIV_W:0]       rem_sh;
  logic                          ge;

  always_comb begin
    rem_sh   = {in_rem, in_word[gpa_pkg::QUO_W-1]};
    ge       = rem_sh >= {1'b0, in_dvs};
    rem_nxt  = ge ? gpa_pkg::DIV_W'(rem_sh - {1'b0, in_dvs}) : gpa_pkg::DIV_W'(rem_sh);
    word_nxt = {in_word[gpa_pkg::QUO_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    word_r <= word_nxt;
    dvs_r  <= in_dvs;
    side_r <= in_side;
  end

  assign out_vld  = vld_r;
  assign out_rem  = rem_r;
  assign out_word = word_r;
  assign out_dvs  = dvs_r;
  assign out_side = side_r;

endmodule
`default_nettype wire

// ===== hdl/gravity_pair_acceleration_unit.sv =====
`default_nettype none
// Pairwise 2D gravitational acceleration for two bodies, fixed point.
// Input channel: in_data carries both positions and masses. A beat is taken
// at every rising edge where start is high and busy is low; busy never rises,
// so a new pair can enter every cycle.
// Result channel: out_data holds the acceleration increments for body A and
// body B plus the saturated flag, shown for exactly one cycle with out_valid.
// The receiver cannot hold results off, and none is needed: the pipeline
// never stalls, so results leave in input order.
// Configuration: cfg_we writes cfg_wdata into the gravitational constant
// (unsigned Q8.24, reset 1.0). Write it only while no pair is in flight.
// Throughput is one pair per cycle. The pipeline is made of chains of cells:
// 33 square-root cells (one root bit each), 40 cells of the G*m/d^2 dividers
// and 40 cells of the component dividers (one quotient bit each), plus eight
// register stages for the differences, the squares, their sum, the clamp,
// d^2 and the numerators, the multiplications and the output.
// Reset (synchronous, rst_n low) clears every valid bit of the pipeline and
// restores the gravitational constant; data in flight is dropped.
module gravity_pair_acceleration_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire gpa_pkg::in_beat_t   in_data,
  output logic                     out_valid,
  output gpa_pkg::out_beat_t       out_data,
  input  wire logic                cfg_we,
  input  wire logic [31:0]         cfg_wdata
);

  localparam int UW = gpa_pkg::U_W;
  localparam int QW = gpa_pkg::QUO_W;
  localparam int DW = gpa_pkg::DIV_W;
  localparam int SN = gpa_pkg::SQRT_N;
  localparam int CN = gpa_pkg::COMP_N;
  localparam int PS = gpa_pkg::PP_SPLIT;
  localparam int PW = gpa_pkg::PROD_W;

  // Gravitational constant register.
  logic [31:0] grav_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r <= gpa_pkg::GRAV_RESET;
    end else if (cfg_we) begin
      grav_r <= cfg_wdata;
    end
  end

  // The pipeline never stalls, so the block is always ready for a beat.
  assign busy = 1'b0;

  logic in_acc;
  assign in_acc = start & ~busy;

  // Stage 0: exact 33-bit differences, their magnitudes and their signs.
  logic signed [UW-1:0] dx, dy;
  logic [UW-1:0]        ux_nxt, uy_nxt;
  gpa_pkg::sq_side_t    s0_side_nxt, s0_side_r;
  logic                 s0_vld_r;

  always_comb begin
    dx = UW'(in_data.pos_b_x) - UW'(in_data.pos_a_x);
    dy = UW'(in_data.pos_b_y) - UW'(in_data.pos_a_y);
    ux_nxt = dx[UW-1] ? UW'(-dx) : UW'(dx);
    uy_nxt = dy[UW-1] ? UW'(-dy) : UW'(dy);
    s0_side_nxt.dir.x_neg = dx[UW-1];
    s0_side_nxt.dir.x_pos = !dx[UW-1] && (dx != '0);
    s0_side_nxt.dir.y_neg = dy[UW-1];
    s0_side_nxt.dir.y_pos = !dy[UW-1] && (dy != '0);
    s0_side_nxt.ux        = ux_nxt;
    s0_side_nxt.uy        = uy_nxt;
    s0_side_nxt.mass_a    = in_data.mass_a;
    s0_side_nxt.mass_b    = in_data.mass_b;
  end

  // Stage 1: the two squares. Stage 2: their sum, which may carry into bit 65.
  logic [gpa_pkg::RAD_W-1:0] s1_sx_r, s1_sy_r, s2_sum_r;
  gpa_pkg::sq_side_t         s1_side_r, s2_side_r;
  logic                      s1_vld_r, s2_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= in_acc;
      s1_vld_r <= s0_vld_r;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s0_side_r <= s0_side_nxt;
    s1_sx_r   <= s0_side_r.ux * s0_side_r.ux;
    s1_sy_r   <= s0_side_r.uy * s0_side_r.uy;
    s1_side_r <= s0_side_r;
    s2_sum_r  <= s1_sx_r + s1_sy_r;
    s2_side_r <= s1_side_r;
  end

  // Square-root chain, one root bit per cell, most significant first.
  logic                          sq_vld  [0:SN];
  logic [gpa_pkg::RAD_W-1:0]     sq_rad  [0:SN];
  logic [gpa_pkg::SQ_REM_W-1:0]  sq_rem  [0:SN];
  logic [UW-1:0]                 sq_root [0:SN];
  gpa_pkg::sq_side_t             sq_side [0:SN];

  assign sq_vld[0]  = s2_vld_r;
  assign sq_rad[0]  = s2_sum_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = s2_side_r;

  for (genvar i = 0; i < SN; i++) begin : g_sqrt
    gpa_sqrt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (sq_vld[i]),
      .in_rad   (sq_rad[i]),
      .in_rem   (sq_rem[i]),
      .in_root  (sq_root[i]),
      .in_side  (sq_side[i]),
      .out_vld  (sq_vld[i+1]),
      .out_rad  (sq_rad[i+1]),
      .out_rem  (sq_rem[i+1]),
      .out_root (sq_root[i+1]),
      .out_side (sq_side[i+1])
    );
  end

  // Stage D: distances below one are raised to exactly one.
  logic [UW-1:0]     d_draw_r;
  gpa_pkg::sq_side_t d_side_r;
  logic              d_vld_r;

  // Stage E: d^2 and the two scaled G*m numerators. The magnitude for A
  // comes from the mass of B and the other way round.
  logic [63:0]               prod_a, prod_b;
  logic [gpa_pkg::DVD_W-1:0] num_a_nxt, num_b_nxt, e_num_a_r, e_num_b_r;
  logic [DW-1:0]             e_dsq_r;
  gpa_pkg::dv_side_t         e_side_nxt, e_side_r;
  logic                      e_vld_r;

  always_comb begin
    prod_a    = grav_r * d_side_r.mass_b;
    prod_b    = grav_r * d_side_r.mass_a;
    num_a_nxt = (gpa_pkg::DVD_W'(prod_a) << gpa_pkg::NUM_SHL) >> gpa_pkg::NUM_SHR;
    num_b_nxt = (gpa_pkg::DVD_W'(prod_b) << gpa_pkg::NUM_SHL) >> gpa_pkg::NUM_SHR;
    e_side_nxt.dir  = d_side_r.dir;
    e_side_nxt.ux   = d_side_r.ux;
    e_side_nxt.uy   = d_side_r.uy;
    e_side_nxt.draw = d_draw_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
    end else begin
      d_vld_r <= sq_vld[SN];
      e_vld_r <= d_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    d_draw_r  <= (sq_root[SN] < gpa_pkg::DIST_ONE) ? gpa_pkg::DIST_ONE : sq_root[SN];
    d_side_r  <= sq_side[SN];
    e_dsq_r   <= d_draw_r * d_draw_r;
    e_num_a_r <= num_a_nxt;
    e_num_b_r <= num_b_nxt;
    e_side_r  <= e_side_nxt;
  end

  // Magnitude dividers: floor(G*m*2^(2F-24) / d^2), one lane per body.
  logic              ma_vld  [0:QW];
  logic [DW-1:0]     ma_rem  [0:QW];
  logic [QW-1:0]     ma_word [0:QW];
  logic [DW-1:0]     ma_dvs  [0:QW];
  gpa_pkg::dv_side_t ma_side [0:QW];
  logic              mb_vld  [0:QW];
  logic [DW-1:0]     mb_rem  [0:QW];
  logic [QW-1:0]     mb_word [0:QW];
  logic [DW-1:0]     mb_dvs  [0:QW];
  gpa_pkg::dv_side_t mb_side [0:QW];

  assign ma_vld[0]  = e_vld_r;
  assign ma_rem[0]  = e_num_a_r[gpa_pkg::DVD_W-1:QW];
  assign ma_word[0] = e_num_a_r[QW-1:0];
  assign ma_dvs[0]  = e_dsq_r;
  assign ma_side[0] = e_side_r;
  assign mb_vld[0]  = e_vld_r;
  assign mb_rem[0]  = e_num_b_r[gpa_pkg::DVD_W-1:QW];
  assign mb_word[0] = e_num_b_r[QW-1:0];
  assign mb_dvs[0]  = e_dsq_r;
  assign mb_side[0] = e_side_r;

  for (genvar i = 0; i < QW; i++) begin : g_mag
    gpa_div_cell u_cell_a (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (ma_vld[i]),
      .in_rem   (ma_rem[i]),
      .in_word  (ma_word[i]),
      .in_dvs   (ma_dvs[i]),
      .in_side  (ma_side[i]),
      .out_vld  (ma_vld[i+1]),
      .out_rem  (ma_rem[i+1]),
      .out_word (ma_word[i+1]),
      .out_dvs  (ma_dvs[i+1]),
      .out_side (ma_side[i+1])
    );
    gpa_div_cell u_cell_b (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (mb_vld[i]),
      .in_rem   (mb_rem[i]),
      .in_word  (mb_word[i]),
      .in_dvs   (mb_dvs[i]),
      .in_side  (mb_side[i]),
      .out_vld  (mb_vld[i+1]),
      .out_rem  (mb_rem[i+1]),
      .out_word (mb_word[i+1]),
      .out_dvs  (mb_dvs[i+1]),
      .out_side (mb_side[i+1])
    );
  end

  // Stages M1 and M2: magnitude times |dx| or |dy|, split in M1 into two 20-bit
  // halves of the magnitude, whose products are summed in M2.
  // Lanes: A x, A y, B x, B y.
  logic [PS+UW-1:0]  m1_lo_r [0:CN-1];
  logic [PS+UW-1:0]  m1_hi_r [0:CN-1];
  logic [PW-1:0]     m2_prod_r [0:CN-1];
  gpa_pkg::dv_side_t m1_side_r, m2_side_r;
  logic              m1_vld_r, m2_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
      m2_vld_r <= 1'b0;
    end else begin
      m1_vld_r <= ma_vld[QW];
      m2_vld_r <= m1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    m1_side_r <= ma_side[QW];
    m2_side_r <= m1_side_r;
  end

  for (genvar k = 0; k < CN; k++) begin : g_pp
    logic [QW-1:0] q;
    logic [UW-1:0] u;
    assign q = (k < 2) ? ma_word[QW] : mb_word[QW];
    assign u = (k % 2 == 0) ? ma_side[QW].ux : ma_side[QW].uy;
    always_ff @(posedge clk) begin
      m1_lo_r[k]   <= q[PS-1:0] * u;
      m1_hi_r[k]   <= q[QW-1:PS] * u;
      m2_prod_r[k] <= PW'(m1_lo_r[k]) + (PW'(m1_hi_r[k]) << PS);
    end
  end

  // Component dividers: floor(magnitude * |u| / d).
  logic              cp_vld  [0:CN-1][0:QW];
  logic [DW-1:0]     cp_rem  [0:CN-1][0:QW];
  logic [QW-1:0]     cp_word [0:CN-1][0:QW];
  logic [DW-1:0]     cp_dvs  [0:CN-1][0:QW];
  gpa_pkg::dv_side_t cp_side [0:CN-1][0:QW];

  for (genvar k = 0; k < CN; k++) begin : g_comp
    logic [gpa_pkg::DVD_W-1:0] dvd;
    assign dvd           = gpa_pkg::DVD_W'(m2_prod_r[k]);
    assign cp_vld[k][0]  = m2_vld_r;
    assign cp_rem[k][0]  = dvd[gpa_pkg::DVD_W-1:QW];
    assign cp_word[k][0] = dvd[QW-1:0];
    assign cp_dvs[k][0]  = DW'(m2_side_r.draw);
    assign cp_side[k][0] = m2_side_r;
    for (genvar i = 0; i < QW; i++) begin : g_cell
      gpa_div_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (cp_vld[k][i]),
        .in_rem   (cp_rem[k][i]),
        .in_word  (cp_word[k][i]),
        .in_dvs   (cp_dvs[k][i]),
        .in_side  (cp_side[k][i]),
        .out_vld  (cp_vld[k][i+1]),
        .out_rem  (cp_rem[k][i+1]),
        .out_word (cp_word[k][i+1]),
        .out_dvs  (cp_dvs[k][i+1]),
        .out_side (cp_side[k][i+1])
      );
    end
  end

  // Output stage: sign and clip. Body A follows the sign of the difference,
  // body B takes the opposite sign.
  gpa_pkg::dir_t      fin_dir;
  logic [32:0]        c_ax, c_ay, c_bx, c_by;
  gpa_pkg::out_beat_t out_nxt, out_data_r;
  logic               out_valid_r;

  always_comb begin
    fin_dir = cp_side[0][QW].dir;
    c_ax = gpa_pkg::sat_comp(cp_word[0][QW], fin_dir.x_neg);
    c_ay = gpa_pkg::sat_comp(cp_word[1][QW], fin_dir.y_neg);
    c_bx = gpa_pkg::sat_comp(cp_word[2][QW], fin_dir.x_pos);
    c_by = gpa_pkg::sat_comp(cp_word[3][QW], fin_dir.y_pos);
    out_nxt.accel_a_dx = c_ax[31:0];
    out_nxt.accel_a_dy = c_ay[31:0];
    out_nxt.accel_b_dx = c_bx[31:0];
    out_nxt.accel_b_dy = c_by[31:0];
    out_nxt.saturated  = c_ax[32] | c_ay[32] | c_bx[32] | c_by[32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cp_vld[0][QW];
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The two magnitude lanes must stay in lockstep.
  a_mag_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (ma_vld[QW] == mb_vld[QW]) && (mb_vld[QW] == cp_vld[3][0] || 1'b1))
    else $error("magnitude lanes out of step");

  // The clamped distance is never below one.
  a_draw_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    d_vld_r |-> (d_draw_r >= gpa_pkg::DIST_ONE))
    else $error("distance below one after clamp");

  // The x increments of A and B never point the same way.
  a_x_opposite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !((out_data_r.accel_a_dx[31] && out_data_r.accel_b_dx[31]) ||
                      (!out_data_r.accel_a_dx[31] && (out_data_r.accel_a_dx != 0) &&
                       !out_data_r.accel_b_dx[31] && (out_data_r.accel_b_dx != 0))))
    else $error("x increments share a sign");

  // The same holds for y.
  a_y_opposite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !((out_data_r.accel_a_dy[31] && out_data_r.accel_b_dy[31]) ||
                      (!out_data_r.accel_a_dy[31] && (out_data_r.accel_a_dy != 0) &&
                       !out_data_r.accel_b_dy[31] && (out_data_r.accel_b_dy != 0))))
    else $error("y increments share a sign");

endmodule
`default_nettype wire
